// ===== hdl/indexed_record_list_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro expects clk_i in the scope where it is used; IRL_ASSERT also expects rst_ni.
`ifndef INDEXED_RECORD_LIST_MACROS_SVH
`define INDEXED_RECORD_LIST_MACROS_SVH

`ifndef SYNTH
`define IRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IRL_ASSERT(lbl, prop, msg)
`define IRL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/irl_pkg.sv =====
package irl_pkg;

  localparam int Depth       = 64;
  localparam int RecordBytes = 8;
  localparam int RecordW     = RecordBytes * 8;
  localparam int DataW       = 64;
  localparam int OpW         = 3;
  localparam int IdxW        = 7;
  localparam int CapW        = 7;
  localparam int CountOutW   = 7;
  localparam int CountW      = $clog2(Depth + 1);
  localparam int PosW        = $clog2(Depth);
  localparam int CmpW        = (CountW > IdxW) ? CountW : IdxW;

  localparam logic [CapW-1:0] CapReset = CapW'(64);

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PLAN_NONE,
    PLAN_INSERT,
    PLAN_DELETE,
    PLAN_WRITE
  } plan_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_UP,
    CELL_DOWN
  } cell_op_e;

  typedef struct packed {
    plan_e           kind;
    logic [PosW-1:0] pos;
    logic            rd;
    logic            status;
  } plan_t;

  typedef struct packed {
    cell_op_e op;
    logic     sel;
  } cell_ctl_t;

endpackage

// ===== hdl/indexed_record_list.sv =====
// Channel   Direction  Handshake                  Word
// command   in         start_i while !busy_o      operation_i, index_i, record_i
// result    out        done_o strobe, one cycle   status_o, read_record_o, count_o
// config    in         cfg_valid_i & cfg_ready_o  cfg_capacity_i
//
// One command per cycle: each cell of the record row loads, shifts from a neighbor
// or holds at the edge that accepts the command, so busy_o stays low.
// The result appears on the cycle after acceptance, from the result register.
// Read data comes from an OR over the cells' select-gated outputs.
// Reset clears the held count, the capacity (to 64) and the strobe; records and result registers are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "indexed_record_list_macros.svh"

module indexed_record_list (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [irl_pkg::OpW-1:0]        operation_i,
  input  logic [irl_pkg::IdxW-1:0]       index_i,
  input  logic [irl_pkg::DataW-1:0]      record_i,
  output logic                           done_o,
  output logic                           status_o,
  output logic [irl_pkg::DataW-1:0]      read_record_o,
  output logic [irl_pkg::CountOutW-1:0]  count_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [irl_pkg::CapW-1:0]       cfg_capacity_i
);

  logic                          accept;
  irl_pkg::plan_t                plan;
  logic [irl_pkg::CountW-1:0]    held, held_next;
  logic [irl_pkg::RecordW-1:0]   new_rec;
  logic [irl_pkg::RecordW-1:0]   rec   [irl_pkg::Depth];
  logic [irl_pkg::RecordW-1:0]   rd    [irl_pkg::Depth];
  logic [irl_pkg::RecordW-1:0]   rd_bus;

  logic                          done_q;
  logic                          status_q;
  logic [irl_pkg::RecordW-1:0]   rdata_q;
  logic [irl_pkg::CountOutW-1:0] count_q;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign new_rec = record_i[irl_pkg::RecordW-1:0];

  irl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .operation_i    (operation_i),
    .index_i        (index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .plan_o         (plan),
    .held_o         (held),
    .held_next_o    (held_next)
  );

  for (genvar k = 0; k < irl_pkg::Depth; k++) begin : g_cell
    localparam logic [irl_pkg::CountW-1:0] K = irl_pkg::CountW'(k);
    irl_pkg::cell_ctl_t          ctl;
    logic [irl_pkg::CountW-1:0]  pos_x;
    logic [irl_pkg::RecordW-1:0] lower, upper;

    assign pos_x = irl_pkg::CountW'(plan.pos);

    always_comb begin
      ctl.op  = irl_pkg::CELL_HOLD;
      ctl.sel = accept && plan.rd && (pos_x == K);
      if (accept) begin
        unique case (plan.kind)
          irl_pkg::PLAN_INSERT: begin
            if (K == pos_x) begin
              ctl.op = irl_pkg::CELL_LOAD;
            end else if (K > pos_x && K <= held) begin
              ctl.op = irl_pkg::CELL_UP;
            end
          end
          irl_pkg::PLAN_DELETE: begin
            // pull the tail down over the removed slot
            if (K >= pos_x && (K + irl_pkg::CountW'(1)) < held) begin
              ctl.op = irl_pkg::CELL_DOWN;
            end
          end
          irl_pkg::PLAN_WRITE: begin
            if (K == pos_x) begin
              ctl.op = irl_pkg::CELL_LOAD;
            end
          end
          default: begin
            ctl.op = irl_pkg::CELL_HOLD;
          end
        endcase
      end
    end

    if (k == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = rec[k-1];
    end
    if (k == irl_pkg::Depth - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = rec[k+1];
    end

    irl_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .new_i   (new_rec),
      .lower_i (lower),
      .upper_i (upper),
      .rec_o   (rec[k]),
      .rd_o    (rd[k])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < irl_pkg::Depth; i++) begin
      rd_bus = rd_bus | rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= plan.status;
      rdata_q  <= rd_bus;
      count_q  <= irl_pkg::CountOutW'(held_next);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_record_o = irl_pkg::DataW'(rdata_q);
  assign count_o       = count_q;

  `IRL_ASSERT(a_done_follows, accept |=> done_o, "accepted command gave no result")
  `IRL_ASSERT(a_no_spurious, !accept |=> !done_o, "result without command")
  `IRL_ASSERT(a_reject_zero, (done_o && status_o) |-> (read_record_o == '0), "rejected op returned data")

endmodule

// ===== hdl/irl_cell.sv =====
module irl_cell (
  input  logic                     clk_i,
  input  irl_pkg::cell_ctl_t       ctl_i,
  input  logic [irl_pkg::RecordW-1:0] new_i,
  input  logic [irl_pkg::RecordW-1:0] lower_i,
  input  logic [irl_pkg::RecordW-1:0] upper_i,
  output logic [irl_pkg::RecordW-1:0] rec_o,
  output logic [irl_pkg::RecordW-1:0] rd_o
);

  logic [irl_pkg::RecordW-1:0] rec_q, rec_d;

  always_comb begin
    unique case (ctl_i.op)
      irl_pkg::CELL_LOAD: rec_d = new_i;
      irl_pkg::CELL_UP:   rec_d = lower_i;
      irl_pkg::CELL_DOWN: rec_d = upper_i;
      default:            rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;
  // only the addressed cell drives the read bus
  assign rd_o  = ctl_i.sel ? rec_q : '0;

endmodule

// ===== hdl/irl_ctrl.sv =====
`include "indexed_record_list_macros.svh"

module irl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [irl_pkg::OpW-1:0]       operation_i,
  input  logic [irl_pkg::IdxW-1:0]      index_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irl_pkg::CapW-1:0]      cfg_capacity_i,
  output irl_pkg::plan_t                plan_o,
  output logic [irl_pkg::CountW-1:0]    held_o,
  output logic [irl_pkg::CountW-1:0]    held_next_o
);

  logic [irl_pkg::CapW-1:0]   cap_q;
  logic [irl_pkg::CountW-1:0] held_q, held_d;
  logic [irl_pkg::CmpW-1:0]   held_x, idx_x, cap_x, lim_x;
  logic                       room;
  irl_pkg::plan_t             plan;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= irl_pkg::CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_capacity_i;
    end
  end

  assign held_x = irl_pkg::CmpW'(held_q);
  assign idx_x  = irl_pkg::CmpW'(index_i);
  assign cap_x  = irl_pkg::CmpW'(cap_q);
  // saturate capacity to the number of cells
  assign lim_x  = (cap_x > irl_pkg::CmpW'(irl_pkg::Depth)) ?
                  irl_pkg::CmpW'(irl_pkg::Depth) : cap_x;
  assign room   = held_x < lim_x;

  always_comb begin
    plan.kind   = irl_pkg::PLAN_NONE;
    plan.pos    = '0;
    plan.rd     = 1'b0;
    plan.status = 1'b1;
    unique case (operation_i)
      irl_pkg::OP_APPEND: begin
        if (room) begin
          plan.kind   = irl_pkg::PLAN_INSERT;
          plan.pos    = held_x[irl_pkg::PosW-1:0];
          plan.status = 1'b0;
        end
      end
      irl_pkg::OP_INSERT: begin
        if (room && idx_x <= held_x) begin
          plan.kind   = irl_pkg::PLAN_INSERT;
          plan.pos    = idx_x[irl_pkg::PosW-1:0];
          plan.status = 1'b0;
        end
      end
      irl_pkg::OP_DELETE: begin
        if (idx_x < held_x) begin
          plan.kind   = irl_pkg::PLAN_DELETE;
          plan.pos    = idx_x[irl_pkg::PosW-1:0];
          plan.status = 1'b0;
        end
      end
      irl_pkg::OP_READ: begin
        if (idx_x < held_x) begin
          plan.pos    = idx_x[irl_pkg::PosW-1:0];
          plan.rd     = 1'b1;
          plan.status = 1'b0;
        end
      end
      irl_pkg::OP_WRITE: begin
        if (idx_x < held_x) begin
          plan.kind   = irl_pkg::PLAN_WRITE;
          plan.pos    = idx_x[irl_pkg::PosW-1:0];
          plan.status = 1'b0;
        end
      end
      default: begin
        plan.status = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (plan.kind)
      irl_pkg::PLAN_INSERT: held_d = held_q + irl_pkg::CountW'(1);
      irl_pkg::PLAN_DELETE: held_d = held_q - irl_pkg::CountW'(1);
      default:              held_d = held_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (accept_i) begin
      held_q <= held_d;
    end
  end

  assign plan_o      = plan;
  assign held_o      = held_q;
  assign held_next_o = held_d;

  `IRL_ASSERT(a_held_bound, held_q <= irl_pkg::CountW'(irl_pkg::Depth), "count beyond depth")
  `IRL_ASSERT(a_insert_grows, (accept_i && plan.kind == irl_pkg::PLAN_INSERT) |=> (held_q == $past(held_q) + 1'b1), "insert did not grow count")
  `IRL_ASSERT(a_reject_keeps, (accept_i && plan.status) |=> $stable(held_q), "rejected op changed count")

endmodule
